// ----- rtl/core/bcg_pkg.sv -----
// Shared types, constants and codes of the battery charge gauge.
package bcg_pkg;

   // Burst and sample limits
   localparam int unsigned MAX_SAMPLES  = 255;
   localparam int unsigned SAMPLE_WIDTH = 16;

   // Field widths
   localparam int unsigned SUM_W   = 24;
   localparam int unsigned TALLY_W = 8;
   localparam int unsigned MV_W    = 20;
   localparam int unsigned PCT_W   = 7;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 24;

   // Shared divider geometry: dividend is left-aligned, one quotient bit a cycle
   localparam int unsigned DIV_DND_W = 50;
   localparam int unsigned DIV_DSR_W = 24;
   localparam int unsigned DIV_CNT_W = 6;

   // Per-operation dividend widths (iterations of the divider)
   localparam logic [DIV_CNT_W-1:0] AVG_STEPS  = 6'd24;
   localparam logic [DIV_CNT_W-1:0] READ_STEPS = 6'd32;
   localparam logic [DIV_CNT_W-1:0] PACK_STEPS = 6'd50;
   localparam logic [DIV_CNT_W-1:0] CELL_STEPS = 6'd20;
   localparam logic [DIV_CNT_W-1:0] PCT_STEPS  = 6'd27;

   // Chemistry windows, millivolts per cell
   localparam logic [MV_W-1:0] NIMH_MIN_MV = 20'd1050;
   localparam logic [MV_W-1:0] NIMH_MAX_MV = 20'd1300;
   localparam logic [MV_W-1:0] LIPO_MIN_MV = 20'd3100;
   localparam logic [MV_W-1:0] LIPO_MAX_MV = 20'd4100;
   localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;
   localparam logic [MV_W-1:0] MV_LIMIT = 20'hFFFFF;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_MV    = 3'd0,
      CSR_ADC_BITS  = 3'd1,
      CSR_UPPER_R   = 3'd2,
      CSR_LOWER_R   = 3'd3,
      CSR_CELLS     = 3'd4,
      CSR_CHEMISTRY = 3'd5
   } csr_index_type;

   // Chemistry codes
   localparam logic CHEM_NIMH = 1'b0;
   localparam logic CHEM_LIPO = 1'b1;

   // Divider operations
   typedef enum logic [2:0] {
      DIV_AVG,
      DIV_READ,
      DIV_PACK,
      DIV_CELL,
      DIV_PCT
   } div_op_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_READ_MUL,
      ST_READ_GO,
      ST_READ_WAIT,
      ST_PACK_MUL,
      ST_PACK_GO,
      ST_PACK_WAIT,
      ST_CELL_GO,
      ST_CELL_WAIT,
      ST_PCT_MUL,
      ST_PCT_GO,
      ST_PCT_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [15:0] adc_sample;
      logic        last_sample;
   } req_type;

   typedef struct packed {
      logic [15:0]      average_raw;
      logic [MV_W-1:0]  pack_millivolts;
      logic [MV_W-1:0]  cell_millivolts;
      logic [PCT_W-1:0] charge_percent;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ref_millivolts;
      logic [4:0]  adc_bits;
      logic [23:0] upper_resistor_ohms;
      logic [23:0] lower_resistor_ohms;
      logic [7:0]  cell_count;
      logic        chemistry;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic       take;
      logic       div_start;
      div_op_type div_op;
      logic       mul_read;
      logic       mul_pack;
      logic       mul_pct;
      logic       cap_avg;
      logic       cap_read;
      logic       cap_pack;
      logic       cap_cell;
      logic       cap_pct;
      logic       load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic divider_on;
   } status_type;

endpackage

// ----- rtl/core/battery_charge_gauge.sv -----
// Top level of the battery charge gauge: configuration registers, controller and datapath.
//
// Samples of a burst enter on the req_ channel (valid/stall); a transfer happens when
// req_valid is high and req_stall low. A sample without last_sample is summed and the
// block is ready again at once. A sample marked last_sample ends the burst: the block
// raises req_stall and works out the mean, the pack voltage, the cell voltage and the
// charge on one shared divider that yields one quotient bit per cycle, in five divisions
// in turn; when either resistor is zero, the pack division and its multiply are skipped.
// The result sits in an output register on the rsp_ channel; while the receiver stalls it
// holds, and the next burst's samples are still taken. A new burst end waits in its final
// step until that register frees. Registers are written on the csr_ port with
// csr_write_en, csr_index, csr_wdata; the user must write them only while no burst end is
// in progress, and the block itself does not enforce this. Reset (synchronous, active
// high) clears the burst sum and count, drops any pending result and restores the
// register defaults.
module battery_charge_gauge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bcg_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bcg_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_en,
   input  logic [bcg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcg_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import bcg_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_REF_MV:    cfg_in.ref_millivolts      = csr_wdata[15:0];
            CSR_ADC_BITS:  cfg_in.adc_bits            = csr_wdata[4:0];
            CSR_UPPER_R:   cfg_in.upper_resistor_ohms = csr_wdata[23:0];
            CSR_LOWER_R:   cfg_in.lower_resistor_ohms = csr_wdata[23:0];
            CSR_CELLS:     cfg_in.cell_count          = csr_wdata[7:0];
            CSR_CHEMISTRY: cfg_in.chemistry           = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_millivolts      <= 16'd5000;
         cfg_ff.adc_bits            <= 5'd10;
         cfg_ff.upper_resistor_ohms <= '0;
         cfg_ff.lower_resistor_ohms <= '0;
         cfg_ff.cell_count          <= 8'd1;
         cfg_ff.chemistry           <= CHEM_NIMH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_sample),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bcg_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ----- rtl/core/bcg_divider.sv -----
// Shared restoring divider: one quotient bit per cycle over a left-aligned dividend.
module bcg_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bcg_pkg::DIV_DND_W-1:0]    dividend,
   input  logic [bcg_pkg::DIV_DSR_W-1:0]    divisor,
   input  logic [bcg_pkg::DIV_CNT_W-1:0]    steps,
   output logic [bcg_pkg::DIV_DND_W-1:0]    quotient,
   output logic                             done
);
   import bcg_pkg::*;

   logic [DIV_DND_W-1:0] quo_ff, quo_in;
   logic [DIV_DSR_W:0]   rem_ff, rem_in;
   logic [DIV_DSR_W-1:0] dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_DSR_W:0]   trial;
   logic                 fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff[DIV_DSR_W-1:0], quo_ff[DIV_DND_W-1]};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = steps;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[DIV_DND_W-2:0], fits};
         rem_in = fits ? (trial - {1'b0, dsr_ff}) : trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- rtl/core/bcg_datapath.sv -----
// Datapath: burst accumulator, multiply steps, divider operand select and result registers.
module bcg_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bcg_pkg::cfg_type     cfg,
   input  bcg_pkg::req_type     req_data,
   input  bcg_pkg::cmd_type     cmd,
   output bcg_pkg::status_type  status,
   output bcg_pkg::rsp_type     rsp_data
);
   import bcg_pkg::*;

   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [TALLY_W-1:0]   tally_ff, tally_in;
   logic [SUM_W-1:0]     acc_sum;
   logic [TALLY_W-1:0]   acc_tally;
   logic [SUM_W-1:0]     bsum_ff;
   logic [TALLY_W-1:0]   btally_ff;
   logic [15:0]          avg_ff;
   logic [24:0]          reading_ff;
   logic [24:0]          rsum_ff;
   logic [DIV_DND_W-1:0] prod_ff;
   logic [MV_W-1:0]      pack_ff;
   logic [MV_W-1:0]      cell_ff;
   logic [PCT_W-1:0]     pct_ff;
   logic                 below_ff;
   rsp_type              out_ff;

   logic [4:0]           bits;
   logic [15:0]          full;
   logic [TALLY_W-1:0]   cells;
   logic [MV_W-1:0]      min_mv;
   logic [MV_W-1:0]      span_mv;
   logic [MV_W-1:0]      over_min;
   logic [DIV_DND_W-1:0] dnd;
   logic [DIV_DSR_W-1:0] dsr;
   logic [DIV_CNT_W-1:0] steps;
   logic [DIV_DND_W-1:0] quo;
   logic                 div_done;

   // Derived configuration values
   always_comb begin
      if (cfg.adc_bits < 5'd8) begin
         bits = 5'd8;
      end else if (cfg.adc_bits > 5'd16) begin
         bits = 5'd16;
      end else begin
         bits = cfg.adc_bits;
      end
      full    = 16'((17'd1 << bits) - 17'd1);
      cells   = (cfg.cell_count == '0) ? TALLY_W'(1) : cfg.cell_count;
      min_mv  = (cfg.chemistry == CHEM_LIPO) ? LIPO_MIN_MV : NIMH_MIN_MV;
      span_mv = (cfg.chemistry == CHEM_LIPO) ? (LIPO_MAX_MV - LIPO_MIN_MV)
                                             : (NIMH_MAX_MV - NIMH_MIN_MV);
      over_min = cell_ff - min_mv;
   end

   // Accumulate the burst; samples past the limit are dropped
   always_comb begin
      acc_sum   = sum_ff;
      acc_tally = tally_ff;
      if (tally_ff < TALLY_W'(MAX_SAMPLES)) begin
         acc_sum   = sum_ff + SUM_W'(req_data.adc_sample[SAMPLE_WIDTH-1:0]);
         acc_tally = tally_ff + 1'b1;
      end
      sum_in   = sum_ff;
      tally_in = tally_ff;
      if (cmd.take) begin
         sum_in   = req_data.last_sample ? '0 : acc_sum;
         tally_in = req_data.last_sample ? '0 : acc_tally;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         tally_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         tally_ff <= tally_in;
      end
   end

   // Select divider operands for the requested operation
   always_comb begin
      case (cmd.div_op)
         DIV_AVG: begin
            dnd   = {bsum_ff, {(DIV_DND_W-SUM_W){1'b0}}};
            dsr   = DIV_DSR_W'(btally_ff);
            steps = AVG_STEPS;
         end
         DIV_READ: begin
            dnd   = {prod_ff[31:0], {(DIV_DND_W-32){1'b0}}};
            dsr   = DIV_DSR_W'(full);
            steps = READ_STEPS;
         end
         DIV_PACK: begin
            dnd   = prod_ff;
            dsr   = cfg.lower_resistor_ohms;
            steps = PACK_STEPS;
         end
         DIV_CELL: begin
            dnd   = {pack_ff, {(DIV_DND_W-MV_W){1'b0}}};
            dsr   = DIV_DSR_W'(cells);
            steps = CELL_STEPS;
         end
         DIV_PCT: begin
            dnd   = {prod_ff[26:0], {(DIV_DND_W-27){1'b0}}};
            dsr   = DIV_DSR_W'(span_mv);
            steps = PCT_STEPS;
         end
         default: begin
            dnd   = '0;
            dsr   = '0;
            steps = '0;
         end
      endcase
   end

   bcg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dnd),
      .divisor  (dsr),
      .steps    (steps),
      .quotient (quo),
      .done     (div_done)
   );

   // Operand, product and result registers
   always_ff @(posedge clock) begin
      rsum_ff <= 25'(cfg.upper_resistor_ohms) + 25'(cfg.lower_resistor_ohms);
      if (cmd.take && req_data.last_sample) begin
         bsum_ff   <= acc_sum;
         btally_ff <= acc_tally;
      end
      if (cmd.cap_avg) begin
         avg_ff <= (btally_ff == '0) ? '0 : quo[15:0];
      end
      if (cmd.mul_read) begin
         prod_ff <= DIV_DND_W'(32'(cfg.ref_millivolts) * 32'(avg_ff));
      end
      if (cmd.mul_pack) begin
         prod_ff <= reading_ff * rsum_ff;
      end
      if (cmd.mul_pct) begin
         prod_ff  <= DIV_DND_W'(27'(over_min) * 27'(PERCENT_FULL));
         below_ff <= (cell_ff < min_mv);
      end
      // The reading also stands as the pack voltage when there is no divider
      if (cmd.cap_read) begin
         reading_ff <= quo[24:0];
         pack_ff    <= (quo > DIV_DND_W'(MV_LIMIT)) ? MV_LIMIT : quo[MV_W-1:0];
      end
      if (cmd.cap_pack) begin
         pack_ff <= (quo > DIV_DND_W'(MV_LIMIT)) ? MV_LIMIT : quo[MV_W-1:0];
      end
      if (cmd.cap_cell) begin
         cell_ff <= quo[MV_W-1:0];
      end
      if (cmd.cap_pct) begin
         if (below_ff) begin
            pct_ff <= '0;
         end else if (quo > DIV_DND_W'(PERCENT_FULL)) begin
            pct_ff <= PERCENT_FULL;
         end else begin
            pct_ff <= quo[PCT_W-1:0];
         end
      end
      if (cmd.load_out) begin
         out_ff.average_raw     <= avg_ff;
         out_ff.pack_millivolts <= pack_ff;
         out_ff.cell_millivolts <= cell_ff;
         out_ff.charge_percent  <= pct_ff;
      end
   end

   assign status.div_done   = div_done;
   assign status.divider_on = (cfg.upper_resistor_ohms != '0) &&
                              (cfg.lower_resistor_ohms != '0);
   assign rsp_data = out_ff;

endmodule

// ----- rtl/core/bcg_ctrl.sv -----
// Controller: sequences the burst-end computation and runs both handshakes.
module bcg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bcg_pkg::status_type  status,
   output bcg_pkg::cmd_type     cmd
);
   import bcg_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.div_op   = DIV_AVG;
      cmd.take     = take;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (take && req_last) begin
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            cmd.div_op    = DIV_AVG;
            cmd.div_start = 1'b1;
            state_in      = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.cap_avg = 1'b1;
               state_in    = ST_READ_MUL;
            end
         end
         ST_READ_MUL: begin
            cmd.mul_read = 1'b1;
            state_in     = ST_READ_GO;
         end
         ST_READ_GO: begin
            cmd.div_op    = DIV_READ;
            cmd.div_start = 1'b1;
            state_in      = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            if (status.div_done) begin
               cmd.cap_read = 1'b1;
               state_in     = status.divider_on ? ST_PACK_MUL : ST_CELL_GO;
            end
         end
         ST_PACK_MUL: begin
            cmd.mul_pack = 1'b1;
            state_in     = ST_PACK_GO;
         end
         ST_PACK_GO: begin
            cmd.div_op    = DIV_PACK;
            cmd.div_start = 1'b1;
            state_in      = ST_PACK_WAIT;
         end
         ST_PACK_WAIT: begin
            if (status.div_done) begin
               cmd.cap_pack = 1'b1;
               state_in     = ST_CELL_GO;
            end
         end
         ST_CELL_GO: begin
            cmd.div_op    = DIV_CELL;
            cmd.div_start = 1'b1;
            state_in      = ST_CELL_WAIT;
         end
         ST_CELL_WAIT: begin
            if (status.div_done) begin
               cmd.cap_cell = 1'b1;
               state_in     = ST_PCT_MUL;
            end
         end
         ST_PCT_MUL: begin
            cmd.mul_pct = 1'b1;
            state_in    = ST_PCT_GO;
         end
         ST_PCT_GO: begin
            cmd.div_op    = DIV_PCT;
            cmd.div_start = 1'b1;
            state_in      = ST_PCT_WAIT;
         end
         ST_PCT_WAIT: begin
            if (status.div_done) begin
               cmd.cap_pct = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- tb/sv/battery_charge_gauge_tb.sv -----
// Self-checking testbench of the battery charge gauge: directed and random sample bursts.
module battery_charge_gauge_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bcg_pkg::*;

   localparam int unsigned SAMPLE_BUDGET = 1750;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned REPORT_LIMIT  = 10;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   req_type              req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [CSR_DAT_W-1:0] csr_wdata    = '0;

   // Gauge state as the block should hold it
   cfg_type            gauge_cfg;
   logic [SUM_W-1:0]   burst_sum;
   logic [TALLY_W-1:0] burst_tally;
   rsp_type            pending_readings[$];

   int unsigned samples_sent = 0;
   int unsigned error_count  = 0;
   bit          steady       = 1'b0;

   battery_charge_gauge u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial forever #5 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #50_000_000;
      $display("[battery_charge_gauge] ERROR");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 4);
      return $urandom_range(5, 200);
   endfunction

   function automatic void note_failure(string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
   endfunction

   function automatic longint unsigned full_scale();
      int unsigned bits;
      bits = 32'(gauge_cfg.adc_bits);
      if (bits < 8) bits = 8;
      else if (bits > 16) bits = 16;
      return (64'd1 << bits) - 1;
   endfunction

   // Accumulate one sample; on the burst end queue the expected gauge reading
   function automatic void predict_gauge(req_type item);
      longint unsigned avg, reading, pack, cell_mv, min_mv, max_mv, pct, upper, lower, cells;
      rsp_type result;
      if (burst_tally < MAX_SAMPLES) begin
         burst_sum   = burst_sum + SUM_W'(item.adc_sample);
         burst_tally = burst_tally + 1'b1;
      end
      if (!item.last_sample) return;
      avg = (burst_tally != 0) ? 64'(burst_sum) / 64'(burst_tally) : 64'd0;
      avg = avg & 64'hFFFF;
      reading = 64'(gauge_cfg.ref_millivolts) * avg / full_scale();
      upper = 64'(gauge_cfg.upper_resistor_ohms);
      lower = 64'(gauge_cfg.lower_resistor_ohms);
      pack = (upper != 0 && lower != 0) ? reading * (upper + lower) / lower : reading;
      if (pack > MV_LIMIT) pack = 64'(MV_LIMIT);
      cells = (gauge_cfg.cell_count != 0) ? 64'(gauge_cfg.cell_count) : 64'd1;
      cell_mv = pack / cells;
      min_mv = (gauge_cfg.chemistry == CHEM_LIPO) ? 64'(LIPO_MIN_MV) : 64'(NIMH_MIN_MV);
      max_mv = (gauge_cfg.chemistry == CHEM_LIPO) ? 64'(LIPO_MAX_MV) : 64'(NIMH_MAX_MV);
      if (cell_mv < min_mv) begin
         pct = 0;
      end else begin
         pct = (cell_mv - min_mv) * 64'(PERCENT_FULL) / (max_mv - min_mv);
         if (pct > PERCENT_FULL) pct = 64'(PERCENT_FULL);
      end
      result.average_raw     = avg[15:0];
      result.pack_millivolts = pack[MV_W-1:0];
      result.cell_millivolts = cell_mv[MV_W-1:0];
      result.charge_percent  = pct[PCT_W-1:0];
      pending_readings.push_back(result);
      burst_sum   = '0;
      burst_tally = '0;
   endfunction

   // ADC code that gives the cell voltage under the current settings
   function automatic longint unsigned code_of(longint unsigned cell_mv);
      longint unsigned upper, lower, num, den;
      upper = 64'(gauge_cfg.upper_resistor_ohms);
      lower = 64'(gauge_cfg.lower_resistor_ohms);
      num = cell_mv * 64'(gauge_cfg.cell_count) * full_scale();
      den = 64'(gauge_cfg.ref_millivolts);
      if (upper != 0 && lower != 0) begin
         num = num * lower;
         den = den * (upper + lower);
      end
      return num / den;
   endfunction

   // Zero, all ones, or any value of the given width
   function automatic logic [23:0] wild_value(int unsigned width);
      logic [31:0] mask;
      mask = (32'd1 << width) - 1;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return mask[23:0];
         default: return 24'($urandom & mask);
      endcase
   endfunction

   // Present one sample and hold it until the transfer
   task automatic send_sample(logic [15:0] code, logic last);
      int unsigned gap;
      req_type item;
      gap = steady ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.adc_sample  = code;
      item.last_sample = last;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      samples_sent++;
      predict_gauge(item);
   endtask

   // Drop valid, drain the results and let the block go quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DAT_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_REF_MV:    gauge_cfg.ref_millivolts      = value[15:0];
         CSR_ADC_BITS:  gauge_cfg.adc_bits            = value[4:0];
         CSR_UPPER_R:   gauge_cfg.upper_resistor_ohms = value[23:0];
         CSR_LOWER_R:   gauge_cfg.lower_resistor_ohms = value[23:0];
         CSR_CELLS:     gauge_cfg.cell_count          = value[7:0];
         CSR_CHEMISTRY: gauge_cfg.chemistry           = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [15:0] ref_mv, logic [4:0] bits, logic [23:0] upper,
                                 logic [23:0] lower, logic [7:0] cells, logic chem);
      settle_block();
      write_reg(CSR_REF_MV, CSR_DAT_W'(ref_mv));
      write_reg(CSR_ADC_BITS, CSR_DAT_W'(bits));
      write_reg(CSR_UPPER_R, upper);
      write_reg(CSR_LOWER_R, lower);
      write_reg(CSR_CELLS, CSR_DAT_W'(cells));
      write_reg(CSR_CHEMISTRY, CSR_DAT_W'(chem));
   endtask

   // Register defaults after reset, single samples and one short burst
   task automatic test_reset_defaults();
      send_sample(16'd0, 1'b1);
      send_sample(16'd1023, 1'b1);
      send_sample(16'd240, 1'b1);
      // oversized code above the 10-bit full scale
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'd300, 1'b0);
      send_sample(16'd301, 1'b0);
      send_sample(16'd302, 1'b1);
   endtask

   // Resistor divider on, and with only one resistor set
   task automatic test_divider_and_chemistry();
      apply_settings(16'd3300, 5'd12, 24'd30000, 24'd10000, 8'd3, CHEM_LIPO);
      send_sample(16'd3500, 1'b1);
      send_sample(16'd4095, 1'b1);
      apply_settings(16'd3300, 5'd12, 24'd30000, 24'd0, 8'd3, CHEM_LIPO);
      send_sample(16'd4095, 1'b1);
      apply_settings(16'd3300, 5'd12, 24'd0, 24'd10000, 8'd3, CHEM_LIPO);
      send_sample(16'd4095, 1'b1);
   endtask

   // Register extremes: zero reference, resolution clamps, zero cells, saturated pack
   task automatic test_register_extremes();
      apply_settings(16'd0, 5'd10, 24'd0, 24'd0, 8'd1, CHEM_NIMH);
      send_sample(16'd1023, 1'b1);
      apply_settings(16'hFFFF, 5'd0, 24'hFFFFFF, 24'd1, 8'd0, CHEM_LIPO);
      send_sample(16'd255, 1'b1);
      apply_settings(16'hFFFF, 5'd31, 24'hFFFFFF, 24'hFFFFFF, 8'd255, CHEM_NIMH);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      apply_settings(16'd1, 5'd16, 24'd1, 24'hFFFFFF, 8'd255, CHEM_LIPO);
      send_sample(16'hFFFF, 1'b1);
      apply_settings(16'd5000, 5'd8, 24'd0, 24'd0, 8'd1, CHEM_NIMH);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'd60, 1'b1);
   endtask

   // Samples past the burst limit are dropped, a dropped last still ends the burst
   task automatic test_burst_overflow();
      apply_settings(16'hFFFF, 5'd16, 24'd0, 24'd0, 8'd1, CHEM_LIPO);
      for (int i = 0; i < MAX_SAMPLES; i++) send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0000, 1'b1);
      // burst that ends exactly on the limit
      for (int i = 1; i <= MAX_SAMPLES; i++)
         send_sample(16'($urandom_range(0, 16'hFFFF)), i == MAX_SAMPLES);
   endtask

   // Phases of random settings; most aim the codes at the chemistry window
   task automatic test_random_phases();
      bit wild;
      bit chem;
      longint unsigned ref_mv, cells, lower, upper, ratio, top_mv, lo, hi, margin, full;
      int unsigned phase_end, burst_len;
      logic [15:0] code;
      while (samples_sent < SAMPLE_BUDGET) begin
         wild = ($urandom_range(0, 3) == 0);
         lo = 0;
         hi = 0;
         if (wild) begin
            apply_settings(16'(wild_value(16)), 5'(wild_value(5)), wild_value(24),
                           wild_value(24), 8'(wild_value(8)), 1'(wild_value(1)));
         end else begin
            chem   = 1'($urandom_range(0, 1));
            ref_mv = 64'($urandom_range(1000, 5000));
            cells  = 64'($urandom_range(1, 8));
            lower  = 64'($urandom_range(1000, 200000));
            top_mv = chem ? 64'(LIPO_MAX_MV) : 64'(NIMH_MAX_MV);
            // put full scale a quarter above a full pack
            ratio  = cells * top_mv * 5 * 1000 / (4 * ref_mv);
            upper  = (ratio > 1000) ? lower * (ratio - 1000) / 1000 : 0;
            apply_settings(16'(ref_mv), 5'($urandom_range(8, 16)), 24'(upper), 24'(lower),
                           8'(cells), chem);
         end
         full = full_scale();
         if (!wild) begin
            lo = code_of(chem ? 64'(LIPO_MIN_MV) : 64'(NIMH_MIN_MV));
            hi = code_of(top_mv) + 1;
            margin = (hi - lo) / 8 + 1;
            lo = (lo > margin) ? lo - margin : 0;
            hi = (hi + margin < full) ? hi + margin : full;
            if (lo > hi) lo = hi;
         end
         steady    = ($urandom_range(0, 3) == 0);
         phase_end = samples_sent + $urandom_range(60, 200);
         while (samples_sent < phase_end && samples_sent < SAMPLE_BUDGET) begin
            burst_len = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 6)
                                                     : $urandom_range(7, 64);
            for (int i = 1; i <= burst_len; i++) begin
               if (!wild) code = 16'($urandom_range(32'(lo), 32'(hi)));
               else if ($urandom_range(0, 1) != 0) code = 16'($urandom_range(0, 16'hFFFF));
               else code = 16'($urandom_range(0, 32'(full)));
               send_sample(code, i == burst_len);
            end
         end
         steady = 1'b0;
      end
   endtask

   // Receiver side: alternate stall and ready runs of random length
   always @(posedge clock) begin : drive_rsp_stall
      bit          stalling;
      int unsigned rsp_run;
      int unsigned run_len;
      if (reset || steady) begin
         stalling = 1'b0;
         rsp_run  = 0;
      end else if (rsp_run != 0) begin
         rsp_run--;
      end else begin
         stalling = !stalling;
         run_len  = stalling ? idle_length() : $urandom_range(0, 15);
         if (run_len == 0) stalling = 1'b0;
         rsp_run  = (run_len == 0) ? 0 : run_len - 1;
      end
      rsp_stall <= stalling;
   end

   // Compare each result transfer with the oldest expected reading
   always @(posedge clock) begin : check_readings
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_readings.size() == 0) begin
            note_failure($sformatf("unexpected result avg=%0d pack=%0d cell=%0d pct=%0d",
                                   rsp_data.average_raw, rsp_data.pack_millivolts,
                                   rsp_data.cell_millivolts, rsp_data.charge_percent));
         end else begin
            want = pending_readings.pop_front();
            if (rsp_data.average_raw !== want.average_raw ||
                rsp_data.pack_millivolts !== want.pack_millivolts ||
                rsp_data.cell_millivolts !== want.cell_millivolts ||
                rsp_data.charge_percent !== want.charge_percent) begin
               note_failure($sformatf(
                  "mismatch: expected avg=%0d pack=%0d cell=%0d pct=%0d, got avg=%0d pack=%0d cell=%0d pct=%0d",
                  want.average_raw, want.pack_millivolts, want.cell_millivolts,
                  want.charge_percent, rsp_data.average_raw, rsp_data.pack_millivolts,
                  rsp_data.cell_millivolts, rsp_data.charge_percent));
            end
         end
      end
   end

   initial begin
      gauge_cfg = '{ref_millivolts: 16'd5000, adc_bits: 5'd10, upper_resistor_ohms: 24'd0,
                    lower_resistor_ohms: 24'd0, cell_count: 8'd1, chemistry: CHEM_NIMH};
      burst_sum   = '0;
      burst_tally = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_divider_and_chemistry();
      test_register_extremes();
      test_burst_overflow();
      test_random_phases();

      settle_block();
      if (error_count == 0 && pending_readings.size() == 0) begin
         $display("[battery_charge_gauge] OK");
      end else begin
         $display("[battery_charge_gauge] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/bcg_pkg.sv
rtl/core/bcg_divider.sv
rtl/core/bcg_datapath.sv
rtl/core/bcg_ctrl.sv
rtl/core/battery_charge_gauge.sv
tb/sv/battery_charge_gauge_tb.sv
